>>> hdl/vrp_pkg.sv
package vrp_pkg;

    // Fixed widths of the Q16.16 / Q2.14 datapath
    localparam int COORD_W    = 32;              // Q16.16 coordinate
    localparam int TRIG_W     = 16;              // Q2.14 cosine / sine
    localparam int FRAC_SHIFT = 14;              // fraction bits of Q2.14
    localparam int DIFF_W     = COORD_W + 1;     // position minus pivot, exact
    localparam int PROD_W     = DIFF_W + TRIG_W; // one product
    localparam int SUM_W      = PROD_W + 1;      // sum of two products
    localparam int SHR_W      = SUM_W - FRAC_SHIFT;
    localparam int FIN_W      = SHR_W + 1;       // after pivot is added back
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Z = 3'd5;

    // 1.0 in Q2.14
    localparam logic signed [TRIG_W-1:0] COS_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
    } t_vtx_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_pos_x;
        logic signed [COORD_W-1:0] out_pos_y;
        logic signed [COORD_W-1:0] out_pos_z;
        logic signed [COORD_W-1:0] out_norm_x;
        logic signed [COORD_W-1:0] out_norm_y;
        logic signed [COORD_W-1:0] out_norm_z;
    } t_vtx_out;

    // Per-stage load enables of the datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

endpackage

>>> hdl/vertex_rotate_about_pivot_top.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data  (t_vtx_in)
// output    out        o_valid / i_ready    o_data  (t_vtx_out)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One vertex per cycle sustained while the output is not stalled; each vertex reaches o_valid through the stages below.
// Stages: pivot subtract and operand select, multiply, sum and shift,
// pivot add and saturate.
// Each stage advances when empty or when the stage after it advances, so
// bubbles are squeezed out under a stall and nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and loads the config defaults.
module vertex_rotate_about_pivot_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  vrp_pkg::t_vtx_in                      i_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output vrp_pkg::t_vtx_out                     o_data,
    input  logic                                  i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [vrp_pkg::COORD_W-1:0]           i_cfg_data
);
    import vrp_pkg::*;

    // Configuration registers
    t_axis                     r_axis;
    logic signed [TRIG_W-1:0]  r_cos, r_sin;
    logic signed [COORD_W-1:0] r_piv_x, r_piv_y, r_piv_z;

    // Valid bits, one per stage, and the untouched vertex carried alongside
    logic    r_v1, r_v2, r_v3, r_v4;
    t_vtx_in r_p1, r_p2, r_p3, r_p4;

    t_adv adv;

    // Operands into the two rotors
    logic signed [DIFF_W-1:0]  dx, dy, dz, nx, ny, nz;
    logic signed [DIFF_W-1:0]  pa, pb, na, nb;
    logic signed [COORD_W-1:0] piv_u, piv_w;
    logic signed [COORD_W-1:0] pu, pw, nu, nw;

    // Ready chain: a stage moves if it is empty or the next one moves
    always_comb begin
        adv.s4 = !r_v4 || i_ready;
        adv.s3 = !r_v3 || adv.s4;
        adv.s2 = !r_v2 || adv.s3;
        adv.s1 = !r_v1 || adv.s2;
    end

    assign o_ready = adv.s1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis  <= AXIS_X;
            r_cos   <= COS_ONE;
            r_sin   <= '0;
            r_piv_x <= '0;
            r_piv_y <= '0;
            r_piv_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AXIS:    r_axis  <= t_axis'(i_cfg_data[1:0]);
                CFG_COS:     r_cos   <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN:     r_sin   <= i_cfg_data[TRIG_W-1:0];
                CFG_PIVOT_X: r_piv_x <= i_cfg_data;
                CFG_PIVOT_Y: r_piv_y <= i_cfg_data;
                CFG_PIVOT_Z: r_piv_z <= i_cfg_data;
                default: ;  // indexes past the last register are dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv.s1) r_v1 <= i_valid;
            if (adv.s2) r_v2 <= r_v1;
            if (adv.s3) r_v3 <= r_v2;
            if (adv.s4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv.s1) r_p1 <= i_data;
        if (adv.s2) r_p2 <= r_p1;
        if (adv.s3) r_p3 <= r_p2;
        if (adv.s4) r_p4 <= r_p3;
    end

    // Stage 1: pivot moved to the origin, exact in 33 bits; normal only widened.
    // Each axis maps its plane onto (a, b) so that the rotors compute
    // u = c*a - s*b and w = s*a + c*b:
    //   x axis: a=y b=z -> u=y' w=z'
    //   y axis: a=z b=x -> u=z' w=x'
    //   z axis: a=y b=x -> u=y' w=x'
    always_comb begin
        dx = $signed({i_data.pos_x[COORD_W-1], i_data.pos_x})
           - $signed({r_piv_x[COORD_W-1], r_piv_x});
        dy = $signed({i_data.pos_y[COORD_W-1], i_data.pos_y})
           - $signed({r_piv_y[COORD_W-1], r_piv_y});
        dz = $signed({i_data.pos_z[COORD_W-1], i_data.pos_z})
           - $signed({r_piv_z[COORD_W-1], r_piv_z});
        nx = $signed({i_data.norm_x[COORD_W-1], i_data.norm_x});
        ny = $signed({i_data.norm_y[COORD_W-1], i_data.norm_y});
        nz = $signed({i_data.norm_z[COORD_W-1], i_data.norm_z});
        case (r_axis)
            AXIS_X: begin
                pa = dy; pb = dz; na = ny; nb = nz;
                piv_u = r_piv_y; piv_w = r_piv_z;
            end
            AXIS_Y: begin
                pa = dz; pb = dx; na = nz; nb = nx;
                piv_u = r_piv_z; piv_w = r_piv_x;
            end
            default: begin
                // z axis; also fills the rotors harmlessly when no axis is set
                pa = dy; pb = dx; na = ny; nb = nx;
                piv_u = r_piv_y; piv_w = r_piv_x;
            end
        endcase
    end

    // Config must be written only while idle (the block does not enforce this), so the pivots
    // and trig terms read straight from the registers stay valid for every item in flight.
    vrp_rotor u_rot_pos (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_a     (pa),
        .i_b     (pb),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .i_piv_u (piv_u),
        .i_piv_w (piv_w),
        .o_u     (pu),
        .o_w     (pw)
    );

    vrp_rotor u_rot_norm (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_a     (na),
        .i_b     (nb),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .i_piv_u ('0),
        .i_piv_w ('0),
        .o_u     (nu),
        .o_w     (nw)
    );

    // Back to x/y/z; the coordinate along the axis passes through untouched
    always_comb begin
        case (r_axis)
            AXIS_X: begin
                o_data.out_pos_x  = r_p4.pos_x;
                o_data.out_pos_y  = pu;
                o_data.out_pos_z  = pw;
                o_data.out_norm_x = r_p4.norm_x;
                o_data.out_norm_y = nu;
                o_data.out_norm_z = nw;
            end
            AXIS_Y: begin
                o_data.out_pos_x  = pw;
                o_data.out_pos_y  = r_p4.pos_y;
                o_data.out_pos_z  = pu;
                o_data.out_norm_x = nw;
                o_data.out_norm_y = r_p4.norm_y;
                o_data.out_norm_z = nu;
            end
            AXIS_Z: begin
                o_data.out_pos_x  = pw;
                o_data.out_pos_y  = pu;
                o_data.out_pos_z  = r_p4.pos_z;
                o_data.out_norm_x = nw;
                o_data.out_norm_y = nu;
                o_data.out_norm_z = r_p4.norm_z;
            end
            default: begin
                // no axis: vertex passes through unchanged
                o_data.out_pos_x  = r_p4.pos_x;
                o_data.out_pos_y  = r_p4.pos_y;
                o_data.out_pos_z  = r_p4.pos_z;
                o_data.out_norm_x = r_p4.norm_x;
                o_data.out_norm_y = r_p4.norm_y;
                o_data.out_norm_z = r_p4.norm_z;
            end
        endcase
    end

`ifndef SYNTH
    // Nothing comes out in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // A stalled result in the last stage is never dropped
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !i_ready |=> r_v4)
        else $error("stalled result lost");

    // With the last stage free the whole pipe accepts
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v4 || i_ready) |-> o_ready)
        else $error("input stalled while pipe can move");

    // An accepted vertex lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted vertex missing from first stage");

    // Pass-through of the axis coordinate
    a_axis_x_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_axis == AXIS_X |->
            o_data.out_pos_x == r_p4.pos_x && o_data.out_norm_x == r_p4.norm_x)
        else $error("x coordinate altered by rotation about x");
`endif

endmodule

>>> hdl/vrp_rotor.sv
// Four-stage plane rotation of one vector:
//   u = (c*a - s*b) >>> 14 + piv_u,  w = (s*a + c*b) >>> 14 + piv_w, saturated.
module vrp_rotor (
    input  logic                                i_clk,
    input  vrp_pkg::t_adv                       i_adv,
    input  logic signed [vrp_pkg::DIFF_W-1:0]   i_a,
    input  logic signed [vrp_pkg::DIFF_W-1:0]   i_b,
    input  logic signed [vrp_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [vrp_pkg::TRIG_W-1:0]   i_sin,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_piv_u,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_piv_w,
    output logic signed [vrp_pkg::COORD_W-1:0]  o_u,
    output logic signed [vrp_pkg::COORD_W-1:0]  o_w
);
    import vrp_pkg::*;

    localparam logic signed [FIN_W-1:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [FIN_W-1:0] SAT_MIN = -37'sd2147483648;

    logic signed [DIFF_W-1:0]  r_a, r_b;
    logic signed [PROD_W-1:0]  r_ca, r_sb, r_sa, r_cb;
    logic signed [PROD_W-1:0]  n_ca, n_sb, n_sa, n_cb;
    logic signed [SUM_W-1:0]   n_su, n_sw;
    logic signed [SHR_W-1:0]   r_hu, r_hw;
    logic signed [FIN_W-1:0]   n_fu, n_fw;
    logic signed [COORD_W-1:0] r_u, r_w;
    logic signed [COORD_W-1:0] n_u, n_w;

    always_comb begin
        n_ca = r_a * i_cos;
        n_sb = r_b * i_sin;
        n_sa = r_a * i_sin;
        n_cb = r_b * i_cos;
        n_su = $signed({r_ca[PROD_W-1], r_ca}) - $signed({r_sb[PROD_W-1], r_sb});
        n_sw = $signed({r_sa[PROD_W-1], r_sa}) + $signed({r_cb[PROD_W-1], r_cb});
        n_fu = $signed({r_hu[SHR_W-1], r_hu})
             + $signed({{(FIN_W-COORD_W){i_piv_u[COORD_W-1]}}, i_piv_u});
        n_fw = $signed({r_hw[SHR_W-1], r_hw})
             + $signed({{(FIN_W-COORD_W){i_piv_w[COORD_W-1]}}, i_piv_w});
        if (n_fu > SAT_MAX) begin
            n_u = SAT_MAX[COORD_W-1:0];
        end else if (n_fu < SAT_MIN) begin
            n_u = SAT_MIN[COORD_W-1:0];
        end else begin
            n_u = n_fu[COORD_W-1:0];
        end
        if (n_fw > SAT_MAX) begin
            n_w = SAT_MAX[COORD_W-1:0];
        end else if (n_fw < SAT_MIN) begin
            n_w = SAT_MIN[COORD_W-1:0];
        end else begin
            n_w = n_fw[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (i_adv.s2) begin
            r_ca <= n_ca;
            r_sb <= n_sb;
            r_sa <= n_sa;
            r_cb <= n_cb;
        end
        // arithmetic shift by 14: keep the upper bits (floor)
        if (i_adv.s3) begin
            r_hu <= n_su[SUM_W-1:FRAC_SHIFT];
            r_hw <= n_sw[SUM_W-1:FRAC_SHIFT];
        end
        if (i_adv.s4) begin
            r_u <= n_u;
            r_w <= n_w;
        end
    end

    assign o_u = r_u;
    assign o_w = r_w;

endmodule
